/* rtl/bdq_pkg.sv */
// Shared types and codes for the bounded deque with search.
package bdq_pkg;

    // Operation codes carried by each input item
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_COUNT      = 3'd4,
        OP_SEARCH     = 3'd5,
        OP_REVERSE    = 3'd6,
        OP_DUMP       = 3'd7
    } t_opcode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_res_status;

    // Source of the position field of a result
    typedef enum logic [1:0] {
        POS_ZERO  = 2'd0,
        POS_COUNT = 2'd1,
        POS_SCAN  = 2'd2
    } t_pos_sel;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic        take;      // capture the value of an accepted item
        logic        push;      // store the held value at one end
        logic        pop;       // drop one element at one end
        logic        at_front;  // logical front end for push or pop
        logic        flip;      // toggle the direction flag
        logic        scan_clr;  // restart the walk at the logical front
        logic        scan_inc;  // advance the walk by one element
        logic        rd_en;     // read the element at the walk position
        logic        out_load;  // load the output register
        t_res_status res_status;
        t_pos_sel    pos_sel;
        logic        val_sel;   // value_out from the read element
        logic        res_last;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic empty;
        logic full;
        logic scan_last;  // walk sits on the logical back element
        logic hit;        // read element equals the held value
        logic out_free;   // output register can take a result this cycle
    } t_dp_stat;

endpackage

/* rtl/bdq_dp.sv */
// Datapath: element store, ring pointers, walk counter and output register.
module bdq_dp
    import bdq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [31:0] i_value_in,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_value_out,
    output logic [4:0]         o_position,
    output logic               o_last
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW:0]   CAP_S  = (IW + 1)'(CAPACITY);
    localparam logic [IW-1:0] LAST_I = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);

    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [DATA_WIDTH-1:0] r_value;
    logic [IW-1:0]         r_front, n_front;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_rev, n_rev;
    logic [IW-1:0]         r_scan, n_scan;
    logic                  r_out_valid;
    logic [1:0]            r_status;
    logic [31:0]           r_value_out;
    logic [4:0]            r_position;
    logic                  r_last;

    logic signed [63:0]    w_sx;
    logic [63:0]           w_vz;
    logic [31:0]           w_cnt32;
    logic [31:0]           w_pos32;
    logic [CW-1:0]         w_lidx;
    logic [IW:0]           w_rsum, w_wsum;
    logic [IW-1:0]         w_raddr, w_waddr, w_front_dec;
    logic                  w_phys_front;
    logic                  w_we;

    // Sign-extend the input value, then keep the store width
    assign w_sx = 64'(i_value_in);

    // Map the walk position to a physical slot
    always_comb begin
        w_lidx = r_rev ? (r_count - CW'(1) - CW'(r_scan)) : CW'(r_scan);
        w_rsum = (IW + 1)'(r_front) + (IW + 1)'(w_lidx[IW-1:0]);
        if (w_rsum >= CAP_S) begin
            w_rsum = w_rsum - CAP_S;
        end
        w_raddr = w_rsum[IW-1:0];
    end

    // Pick the write slot and next pointers
    always_comb begin
        w_phys_front = i_cmd.at_front ^ r_rev;
        w_front_dec  = (r_front == '0) ? LAST_I : (r_front - IW'(1));
        w_wsum = (IW + 1)'(r_front) + (IW + 1)'(r_count[IW-1:0]);
        if (w_wsum >= CAP_S) begin
            w_wsum = w_wsum - CAP_S;
        end
        w_waddr = w_phys_front ? w_front_dec : w_wsum[IW-1:0];
        w_we    = i_cmd.push;

        n_front = r_front;
        n_count = r_count;
        n_rev   = r_rev;
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
            if (w_phys_front) begin
                n_front = w_front_dec;
            end
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
            if (w_phys_front) begin
                n_front = (r_front == LAST_I) ? '0 : (r_front + IW'(1));
            end
        end
        if (i_cmd.flip) begin
            n_rev = ~r_rev;
        end

        n_scan = r_scan;
        if (i_cmd.scan_clr) begin
            n_scan = '0;
        end else if (i_cmd.scan_inc) begin
            n_scan = r_scan + IW'(1);
        end
    end

    // Hold pointers, count, direction and walk position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
            r_scan  <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            r_rev   <= n_rev;
            r_scan  <= n_scan;
        end
    end

    // Capture the item value
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_value <= w_sx[DATA_WIDTH-1:0];
        end
    end

    // Element store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= mem[w_raddr];
        end
    end

    // Build the result fields
    assign w_vz    = 64'(r_rdata);
    assign w_cnt32 = 32'(r_count);
    assign w_pos32 = 32'(r_scan) + 32'd1;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status    <= i_cmd.res_status;
            r_value_out <= i_cmd.val_sel ? w_vz[31:0] : 32'd0;
            r_last      <= i_cmd.res_last;
            case (i_cmd.pos_sel)
                POS_COUNT: r_position <= w_cnt32[4:0];
                POS_SCAN:  r_position <= w_pos32[4:0];
                default:   r_position <= 5'd0;
            endcase
        end
    end

    // Report status to the controller
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CAP_C);
    assign o_stat.scan_last = ((CW'(r_scan) + CW'(1)) == r_count);
    assign o_stat.hit       = (r_rdata == r_value);
    assign o_stat.out_free  = ~r_out_valid | i_ready;

    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_value_out = r_value_out;
    assign o_position  = r_position;
    assign o_last      = r_last;

endmodule

/* rtl/bdq_ctrl.sv */
// Controller: sequences each item through execute, read and check steps.
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_opcode,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_READ  = 4'b0100,
        S_CHECK = 4'b1000
    } t_state;

    t_state  r_state, n_state;
    t_opcode r_op, n_op;

    assign o_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        o_cmd.res_status = ST_OK;
        o_cmd.pos_sel    = POS_ZERO;
        o_cmd.res_last   = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_op       = t_opcode'(i_opcode);
                    n_state    = S_EXEC;
                end
            end

            S_EXEC: begin
                case (r_op)
                    OP_PUSH_FRONT, OP_PUSH_BACK: begin
                        if (i_stat.out_free) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.at_front = (r_op == OP_PUSH_FRONT);
                            if (i_stat.full) begin
                                o_cmd.res_status = ST_FULL;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK: begin
                        if (i_stat.out_free) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.at_front = (r_op == OP_POP_FRONT);
                            if (i_stat.empty) begin
                                o_cmd.res_status = ST_EMPTY;
                            end else begin
                                o_cmd.pop = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    OP_COUNT: begin
                        if (i_stat.out_free) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.pos_sel  = POS_COUNT;
                            n_state        = S_IDLE;
                        end
                    end
                    OP_REVERSE: begin
                        if (i_stat.out_free) begin
                            o_cmd.out_load = 1'b1;
                            if (i_stat.empty) begin
                                o_cmd.res_status = ST_EMPTY;
                            end else begin
                                o_cmd.flip = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    OP_SEARCH, OP_DUMP: begin
                        if (i_stat.empty) begin
                            if (i_stat.out_free) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.res_status = (r_op == OP_SEARCH) ? ST_NOT_FOUND
                                                                       : ST_EMPTY;
                                n_state = S_IDLE;
                            end
                        end else begin
                            o_cmd.scan_clr = 1'b1;
                            n_state        = S_READ;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            // Fetch the element at the walk position
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_CHECK;
            end

            // Match or emit the fetched element, then advance or finish
            S_CHECK: begin
                if (r_op == OP_SEARCH) begin
                    if (i_stat.hit) begin
                        if (i_stat.out_free) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.val_sel  = 1'b1;
                            o_cmd.pos_sel  = POS_SCAN;
                            n_state        = S_IDLE;
                        end
                    end else if (i_stat.scan_last) begin
                        if (i_stat.out_free) begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.res_status = ST_NOT_FOUND;
                            n_state          = S_IDLE;
                        end
                    end else begin
                        o_cmd.scan_inc = 1'b1;
                        n_state        = S_READ;
                    end
                end else begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.val_sel  = 1'b1;
                        o_cmd.pos_sel  = POS_SCAN;
                        o_cmd.res_last = i_stat.scan_last;
                        if (i_stat.scan_last) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.scan_inc = 1'b1;
                            n_state        = S_READ;
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the current opcode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_PUSH_FRONT;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

endmodule

/* rtl/bounded_deque_with_search.sv */
// Top level of the bounded deque with search: controller plus datapath.
// A bounded double-ended queue of up to CAPACITY signed values held in a
// circular store; reverse only flips a direction flag, so no data moves.
// Push, pop, count and reverse take an accept and an execute step per item
// and give one result. Search and dump walk the store from the logical front
// through its single read port with registered read data, a read and a check
// step per element: search gives one result, dump one per element with last
// set on the final one (a single empty result when nothing is stored). The
// result sits in an output register, so a new item is accepted while a
// finished result still waits; a stalled output holds the walk in place.
// The store needs no clearing after reset: only occupied entries are read.
module bounded_deque_with_search
    import bdq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_opcode,
    input  logic signed [31:0] i_value_in,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_value_out,
    output logic [4:0]         o_position,
    output logic               o_last
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequence each item
    bdq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_opcode (i_opcode),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    // Store, pointers and result register
    bdq_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value_in  (i_value_in),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_position  (o_position),
        .o_last      (o_last)
    );

endmodule
